[rtl/bdht_pkg.sv]
// Package for the bus device health table: item types, entry record and code constants.
package bdht_pkg;

    // Operation codes carried in the mode field
    typedef logic [2:0] t_mode;
    localparam t_mode MODE_SUCCESS  = 3'd0;
    localparam t_mode MODE_FAILURE  = 3'd1;
    localparam t_mode MODE_REGISTER = 3'd2;
    localparam t_mode MODE_BUS      = 3'd3;
    localparam t_mode MODE_READ     = 3'd4;
    localparam t_mode MODE_FORCE    = 3'd5;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_BAD_ADDR  = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // Bus health codes
    typedef logic [1:0] t_health;
    localparam t_health HEALTH_OK    = 2'd0;
    localparam t_health HEALTH_WARN  = 2'd1;
    localparam t_health HEALTH_ERROR = 2'd2;

    // Configuration register indexes
    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_FAIL_LIMIT    = 1'b0;
    localparam t_cfg_idx CFG_RECOVER_LIMIT = 1'b1;

    localparam int unsigned CFG_W = 8;

    // Input item
    typedef struct packed {
        t_mode      mode;
        logic [6:0] address;
        logic       port;
        logic       force_offline;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_status     status;
        logic        went_offline;
        logic        came_online;
        logic        online;
        logic        known;
        logic [31:0] success_total;
        logic [31:0] failure_total;
        logic [7:0]  failure_run;
        logic [7:0]  success_run;
        t_health     bus_health;
        logic [3:0]  bus_devices;
        logic [3:0]  bus_online;
    } t_out_item;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [6:0]  address;
        logic        port;
        logic        online;
        logic [31:0] transactions;
        logic [31:0] failures;
        logic [7:0]  fail_run;
        logic [7:0]  success_run;
    } t_entry;

    // Event flags raised by a record update
    typedef struct packed {
        logic went_offline;
        logic came_online;
    } t_events;

    // Result with nothing reported: status ok, online set, all else clear
    function automatic t_out_item default_result();
        t_out_item r;
        r        = '0;
        r.status = ST_OK;
        r.online = 1'b1;
        return r;
    endfunction

endpackage

[rtl/bus_device_health_table_unit.sv]
// Top level of the bus device health table: sequencer, table RAM and result register.
//
// Input items arrive on i_in_valid / o_in_stall with payload i_in_item; results
// leave on o_out_valid / i_out_stall with payload o_out_item, one result per item.
// The user writes limits on i_cfg_we/i_cfg_idx/i_cfg_data only when idle; unenforced.
//
// The entries live in one RAM with a registered read. An item is
// handled one at a time: the sequencer walks the used entries one per cycle
// (address lookup or per-port sums), then reads-modifies-writes the hit entry.
// A full walk ends in the done state, from which the result is loaded into
// the output register as the next item becomes acceptable; a lookup stops at
// its hit, and register with address zero or an unused mode goes straight
// from acceptance to the done state. How long an item takes is set mainly by
// the one-entry-per-cycle walk through the RAM read port.
//
// Reset empties the table (the fill count clears, no pass over the RAM) and
// sets both limits to 3. The result register lets the next item be accepted
// while a result waits; if the receiver stalls, the following result is held
// in the sequencer and no further item is accepted until it can be loaded.
module bus_device_health_table_unit #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bdht_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bdht_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_we,
    input  bdht_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [bdht_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned REC_W = $bits(bdht_pkg::t_entry);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MOD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    t_state                r_state;
    bdht_pkg::t_in_item    r_in;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      r_ptr;
    logic                  r_dv;
    logic [IDX_W-1:0]      r_didx;
    logic [IDX_W-1:0]      r_hit;
    bdht_pkg::t_entry      r_rec;
    logic [7:0]            r_fail_limit;
    logic [7:0]            r_recover_limit;
    logic [31:0]           r_succ_sum;
    logic [31:0]           r_fail_sum;
    logic [CNT_W-1:0]      r_devs;
    logic [CNT_W-1:0]      r_onl;
    bdht_pkg::t_health     r_health;
    bdht_pkg::t_out_item   r_pend;
    bdht_pkg::t_out_item   r_out;
    logic                  r_out_vld;

    logic                  w_in_acc;
    logic                  w_can_load;
    logic                  w_full;
    logic                  w_hit;
    logic                  w_scan_done;
    logic                  w_mod_write;
    logic                  w_ram_we;
    logic [IDX_W-1:0]      w_waddr;
    bdht_pkg::t_entry      w_wdata;
    logic [REC_W-1:0]      w_rdata;
    bdht_pkg::t_entry      w_rec;
    bdht_pkg::t_entry      w_new_rec;
    bdht_pkg::t_entry      w_upd_rec;
    bdht_pkg::t_events     w_events;
    bdht_pkg::t_out_item   w_pend_init;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_can_load = !r_out_vld || !i_out_stall;
    assign w_full     = (r_used == CNT_W'(TABLE_DEPTH));
    assign w_rec      = bdht_pkg::t_entry'(w_rdata);

    // Entry under examination matches the looked-up address
    assign w_hit       = (r_state == S_SCAN) && r_dv && (r_in.mode != bdht_pkg::MODE_BUS)
                         && (w_rec.address == r_in.address);
    assign w_scan_done = (r_state == S_SCAN) && !r_dv && (r_ptr == r_used);
    assign w_mod_write = (r_in.mode == bdht_pkg::MODE_SUCCESS)
                         || (r_in.mode == bdht_pkg::MODE_FAILURE)
                         || (r_in.mode == bdht_pkg::MODE_FORCE);

    // Preset result for the item being accepted
    always_comb begin
        w_pend_init = bdht_pkg::default_result();
        if ((i_in_item.mode == bdht_pkg::MODE_REGISTER) && (i_in_item.address == 7'd0)) begin
            w_pend_init.status = bdht_pkg::ST_BAD_ADDR;
        end
    end

    // Fresh record for a new registration
    always_comb begin
        w_new_rec         = '0;
        w_new_rec.address = r_in.address;
        w_new_rec.port    = r_in.port;
        w_new_rec.online  = 1'b1;
    end

    // RAM write: new entry at the fill count, or write-back of the hit entry
    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = r_used[IDX_W-1:0];
        w_wdata  = w_new_rec;
        if (r_state == S_MOD) begin
            w_ram_we = w_mod_write;
            w_waddr  = r_hit;
            w_wdata  = w_upd_rec;
        end else if (w_scan_done && (r_in.mode == bdht_pkg::MODE_REGISTER) && !w_full) begin
            w_ram_we = 1'b1;
        end
    end

    bdht_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (REC_W'(w_wdata)),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    bdht_update u_update (
        .i_mode          (r_in.mode),
        .i_force_offline (r_in.force_offline),
        .i_rec           (r_rec),
        .i_fail_limit    (r_fail_limit),
        .i_recover_limit (r_recover_limit),
        .o_rec           (w_upd_rec),
        .o_events        (w_events)
    );

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit    <= 8'd3;
            r_recover_limit <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdht_pkg::CFG_FAIL_LIMIT:    r_fail_limit    <= i_cfg_data;
                bdht_pkg::CFG_RECOVER_LIMIT: r_recover_limit <= i_cfg_data;
                default:                     r_fail_limit    <= r_fail_limit;
            endcase
        end
    end

    // Sequencer: accept, walk the table, modify, hand over the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in       <= i_in_item;
                        r_ptr      <= '0;
                        r_dv       <= 1'b0;
                        r_succ_sum <= '0;
                        r_fail_sum <= '0;
                        r_devs     <= '0;
                        r_onl      <= '0;
                        r_health   <= bdht_pkg::HEALTH_OK;
                        r_pend     <= w_pend_init;
                        if ((i_in_item.mode == bdht_pkg::MODE_REGISTER)
                            && (i_in_item.address == 7'd0)) begin
                            r_state <= S_DONE;
                        end else if (i_in_item.mode > bdht_pkg::MODE_FORCE) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, previous read examined
                    if (!w_hit && (r_ptr != r_used)) begin
                        r_ptr  <= r_ptr + CNT_W'(1);
                        r_didx <= r_ptr[IDX_W-1:0];
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    // per-port sums for the bus query
                    if (r_dv && (r_in.mode == bdht_pkg::MODE_BUS) && (w_rec.port == r_in.port)) begin
                        r_succ_sum <= sat_add32(r_succ_sum, w_rec.transactions);
                        r_fail_sum <= sat_add32(r_fail_sum, w_rec.failures);
                        r_devs     <= r_devs + CNT_W'(1);
                        if (w_rec.online) begin
                            r_onl <= r_onl + CNT_W'(1);
                            if ((w_rec.failures != '0) && (r_health == bdht_pkg::HEALTH_OK)) begin
                                r_health <= bdht_pkg::HEALTH_WARN;
                            end
                        end else begin
                            r_health <= bdht_pkg::HEALTH_ERROR;
                        end
                    end
                    if (w_hit) begin
                        r_rec   <= w_rec;
                        r_hit   <= r_didx;
                        r_state <= S_MOD;
                    end else if (w_scan_done) begin
                        r_state <= S_DONE;
                        case (r_in.mode)
                            bdht_pkg::MODE_BUS: begin
                                r_pend.success_total <= r_succ_sum;
                                r_pend.failure_total <= r_fail_sum;
                                r_pend.bus_health    <= r_health;
                                r_pend.bus_devices   <= 4'(r_devs);
                                r_pend.bus_online    <= 4'(r_onl);
                            end
                            bdht_pkg::MODE_REGISTER: begin
                                if (w_full) begin
                                    r_pend.status <= bdht_pkg::ST_FULL;
                                end else begin
                                    r_used <= r_used + CNT_W'(1);
                                end
                            end
                            default: begin
                                r_pend.status <= bdht_pkg::ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    // success, failure and force write back this cycle; report the updated record
                    r_pend.known         <= 1'b1;
                    r_pend.online        <= w_upd_rec.online;
                    r_pend.success_total <= w_upd_rec.transactions;
                    r_pend.failure_total <= w_upd_rec.failures;
                    r_pend.failure_run   <= w_upd_rec.fail_run;
                    r_pend.success_run   <= w_upd_rec.success_run;
                    r_pend.went_offline  <= w_events.went_offline;
                    r_pend.came_online   <= w_events.came_online;
                    r_state              <= S_DONE;
                end
                S_DONE: begin
                    if (w_can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && w_can_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_can_load) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("read data flagged valid outside the table walk");

    a_reg_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && (r_state == S_SCAN)) |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("new entry written without fill count advancing");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == S_SCAN) || (r_state == S_MOD)))
        else $error("table write outside walk or modify");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_vld && i_out_stall) |=> (r_state == S_DONE))
        else $error("pending result left while output register occupied");

endmodule

[rtl/bdht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bdht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bdht_update.sv]
// Record update for success, failure and forced state, with online hysteresis.
module bdht_update (
    input  bdht_pkg::t_mode  i_mode,
    input  logic             i_force_offline,
    input  bdht_pkg::t_entry i_rec,
    input  logic [7:0]       i_fail_limit,
    input  logic [7:0]       i_recover_limit,
    output bdht_pkg::t_entry o_rec,
    output bdht_pkg::t_events o_events
);

    always_comb begin
        bdht_pkg::t_entry  rec;
        bdht_pkg::t_events ev;
        rec = i_rec;
        ev  = '0;
        case (i_mode)
            bdht_pkg::MODE_SUCCESS: begin
                // count saturates, failure run clears, success run saturates
                if (rec.transactions != '1) begin
                    rec.transactions = rec.transactions + 32'd1;
                end
                rec.fail_run = '0;
                if (rec.success_run != '1) begin
                    rec.success_run = rec.success_run + 8'd1;
                end
                if (!rec.online && (rec.success_run >= i_recover_limit)) begin
                    rec.online     = 1'b1;
                    ev.came_online = 1'b1;
                end
            end
            bdht_pkg::MODE_FAILURE: begin
                if (rec.failures != '1) begin
                    rec.failures = rec.failures + 32'd1;
                end
                if (rec.fail_run != '1) begin
                    rec.fail_run = rec.fail_run + 8'd1;
                end
                rec.success_run = '0;
                if (rec.online && (rec.fail_run >= i_fail_limit)) begin
                    rec.online      = 1'b0;
                    ev.went_offline = 1'b1;
                end
            end
            bdht_pkg::MODE_FORCE: begin
                rec.online = ~i_force_offline;
            end
            default: begin
                // read and register report the record unchanged
                rec = i_rec;
            end
        endcase
        o_rec    = rec;
        o_events = ev;
    end

endmodule

[tb/sv/bus_device_health_table_unit_tb.sv]
// Self-checking testbench for the bus device health table: directed and random items, scored.
module bus_device_health_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 8;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1150;
    // Mode values the block leaves unused
    localparam bdht_pkg::t_mode MODE_SPARE_LO = 3'd6;
    localparam bdht_pkg::t_mode MODE_SPARE_HI = 3'd7;

    // One device record of the scoreboard's copy of the table
    typedef struct {
        logic [6:0]  addr;
        logic        port;
        logic        online;
        logic [31:0] txn;
        logic [31:0] fails;
        logic [7:0]  fail_run;
        logic [7:0]  ok_run;
    } t_dev_rec;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    bdht_pkg::t_in_item            in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    bdht_pkg::t_out_item           out_item;
    logic                          cfg_we = 1'b0;
    bdht_pkg::t_cfg_idx            cfg_idx = bdht_pkg::CFG_FAIL_LIMIT;
    logic [bdht_pkg::CFG_W-1:0]    cfg_data = '0;

    // Scoreboard copy of the table and limits
    t_dev_rec                      health_table [TABLE_DEPTH];
    int unsigned                   dev_count = 0;
    logic [7:0]                    fail_lim = 8'd3;
    logic [7:0]                    rec_lim = 8'd3;
    bdht_pkg::t_out_item           reports_due [$];

    int unsigned        send_gap_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        items_sent = 0;
    int unsigned        reports_seen = 0;
    int unsigned        mismatches = 0;
    int unsigned        cycle_count = 0;

    bus_device_health_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Table lookup by address over the registered entries
    function automatic int find_dev(logic [6:0] a);
        for (int i = 0; i < dev_count; i++) begin
            if (health_table[i].addr == a) return i;
        end
        return -1;
    endfunction

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bdht_pkg::t_out_item with_record(bdht_pkg::t_out_item r, int i);
        r.online        = health_table[i].online;
        r.success_total = health_table[i].txn;
        r.failure_total = health_table[i].fails;
        r.failure_run   = health_table[i].fail_run;
        r.success_run   = health_table[i].ok_run;
        return r;
    endfunction

    // Applies one item to the scoreboard table and returns the report it should produce
    function automatic bdht_pkg::t_out_item health_report_for(bdht_pkg::t_in_item it);
        bdht_pkg::t_out_item r;
        int hit;
        logic [31:0] ok_sum;
        logic [31:0] fail_sum;
        logic [3:0] n_dev;
        logic [3:0] n_on;
        bdht_pkg::t_health health;
        r = '0;
        r.status = bdht_pkg::ST_OK;
        r.online = 1'b1;
        hit = find_dev(it.address);
        case (it.mode) inside
            bdht_pkg::MODE_REGISTER: begin
                if (it.address == 7'd0) begin
                    r.status = bdht_pkg::ST_BAD_ADDR;
                end else if (hit >= 0) begin
                    r.known = 1'b1;
                    r = with_record(r, hit);
                end else if (dev_count >= TABLE_DEPTH) begin
                    r.status = bdht_pkg::ST_FULL;
                end else begin
                    health_table[dev_count] = '{it.address, it.port, 1'b1,
                                                32'd0, 32'd0, 8'd0, 8'd0};
                    r = with_record(r, dev_count);
                    dev_count++;
                end
            end
            bdht_pkg::MODE_BUS: begin
                ok_sum = '0;
                fail_sum = '0;
                n_dev = '0;
                n_on = '0;
                health = bdht_pkg::HEALTH_OK;
                for (int i = 0; i < dev_count; i++) begin
                    if (health_table[i].port == it.port) begin
                        ok_sum = sat_add32(ok_sum, health_table[i].txn);
                        fail_sum = sat_add32(fail_sum, health_table[i].fails);
                        n_dev++;
                        if (health_table[i].online) n_on++;
                        else health = bdht_pkg::HEALTH_ERROR;
                        if (health_table[i].fails != 0 && health_table[i].online &&
                            health == bdht_pkg::HEALTH_OK) health = bdht_pkg::HEALTH_WARN;
                    end
                end
                r.success_total = ok_sum;
                r.failure_total = fail_sum;
                r.bus_health = health;
                r.bus_devices = n_dev;
                r.bus_online = n_on;
            end
            bdht_pkg::MODE_SUCCESS, bdht_pkg::MODE_FAILURE,
            bdht_pkg::MODE_READ, bdht_pkg::MODE_FORCE: begin
                if (hit < 0) begin
                    r.status = bdht_pkg::ST_NOT_FOUND;
                end else begin
                    r.known = 1'b1;
                    if (it.mode == bdht_pkg::MODE_SUCCESS) begin
                        if (health_table[hit].txn != 32'hFFFF_FFFF) health_table[hit].txn++;
                        health_table[hit].fail_run = '0;
                        if (health_table[hit].ok_run != 8'hFF) health_table[hit].ok_run++;
                        if (!health_table[hit].online && health_table[hit].ok_run >= rec_lim) begin
                            health_table[hit].online = 1'b1;
                            r.came_online = 1'b1;
                        end
                    end else if (it.mode == bdht_pkg::MODE_FAILURE) begin
                        if (health_table[hit].fails != 32'hFFFF_FFFF) health_table[hit].fails++;
                        if (health_table[hit].fail_run != 8'hFF) health_table[hit].fail_run++;
                        health_table[hit].ok_run = '0;
                        if (health_table[hit].online && health_table[hit].fail_run >= fail_lim) begin
                            health_table[hit].online = 1'b0;
                            r.went_offline = 1'b1;
                        end
                    end else if (it.mode == bdht_pkg::MODE_FORCE) begin
                        health_table[hit].online = !it.force_offline;
                    end
                    r = with_record(r, hit);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bdht_pkg::t_in_item make_item(bdht_pkg::t_mode m, logic [6:0] a,
                                                     logic p = 1'b0, logic f = 1'b0);
        bdht_pkg::t_in_item it;
        it.mode = m;
        it.address = a;
        it.port = p;
        it.force_offline = f;
        return it;
    endfunction

    // Sends one item; entered and left at a falling edge, valid left high
    task automatic send_item(bdht_pkg::t_in_item it);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        reports_due.push_back(health_report_for(it));
        items_sent++;
        @(negedge clk);
    endtask

    // Lets every outstanding report come back
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (reports_due.size() != 0) @(negedge clk);
    endtask

    task automatic write_limits(logic [7:0] f, logic [7:0] r);
        wait_quiet();
        cfg_we = 1'b1;
        cfg_idx = bdht_pkg::CFG_FAIL_LIMIT;
        cfg_data = f;
        @(negedge clk);
        cfg_idx = bdht_pkg::CFG_RECOVER_LIMIT;
        cfg_data = r;
        @(negedge clk);
        cfg_we = 1'b0;
        fail_lim = f;
        rec_lim = r;
    endtask

    // Receiver stalls
    always @(negedge clk) begin
        out_stall = recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Scores each report against the oldest one due
    always @(posedge clk) begin : score_reports
        bdht_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
                $error("report with none due: %p", out_item);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("status", want.status, out_item.status);
                check_field("went_offline", want.went_offline, out_item.went_offline);
                check_field("came_online", want.came_online, out_item.came_online);
                check_field("online", want.online, out_item.online);
                check_field("known", want.known, out_item.known);
                check_field("success_total", want.success_total, out_item.success_total);
                check_field("failure_total", want.failure_total, out_item.failure_total);
                check_field("failure_run", want.failure_run, out_item.failure_run);
                check_field("success_run", want.success_run, out_item.success_run);
                check_field("bus_health", want.bus_health, out_item.bus_health);
                check_field("bus_devices", want.bus_devices, out_item.bus_devices);
                check_field("bus_online", want.bus_online, out_item.bus_online);
            end
        end
    end

    // Lookup misses, bad address, new and repeated registration, table full
    task automatic test_registration();
        send_item(make_item(bdht_pkg::MODE_SUCCESS, 7'd5));
        send_item(make_item(bdht_pkg::MODE_BUS, 7'd0, 1'b0));
        send_item(make_item(bdht_pkg::MODE_REGISTER, 7'd0, 1'b1));
        send_item(make_item(bdht_pkg::MODE_REGISTER, 7'd127, 1'b1));
        // second registration keeps the first port
        send_item(make_item(bdht_pkg::MODE_REGISTER, 7'd127, 1'b0));
        for (int a = 1; a <= 7; a++) begin
            send_item(make_item(bdht_pkg::MODE_REGISTER, 7'(a), a[0]));
        end
        send_item(make_item(bdht_pkg::MODE_REGISTER, 7'd100, 1'b0));
    endtask

    // Offline after the failure run, back online after the success run, bus view of both
    task automatic test_hysteresis();
        repeat (3) send_item(make_item(bdht_pkg::MODE_FAILURE, 7'd127));
        send_item(make_item(bdht_pkg::MODE_BUS, 7'd127, 1'b1));
        repeat (3) send_item(make_item(bdht_pkg::MODE_SUCCESS, 7'd127));
        send_item(make_item(bdht_pkg::MODE_BUS, 7'd0, 1'b1));
        send_item(make_item(bdht_pkg::MODE_READ, 7'd127));
    endtask

    // Forced state, unknown read and the unused modes
    task automatic test_forced_and_unused();
        send_item(make_item(bdht_pkg::MODE_FORCE, 7'd1, 1'b0, 1'b1));
        send_item(make_item(bdht_pkg::MODE_FORCE, 7'd1, 1'b1, 1'b0));
        send_item(make_item(bdht_pkg::MODE_READ, 7'd0));
        send_item(make_item(MODE_SPARE_LO, 7'd127, 1'b1, 1'b1));
        send_item(make_item(MODE_SPARE_HI, 7'd1, 1'b1, 1'b1));
    endtask

    // Top limits: state change exactly at 255 and runs saturating beyond it
    task automatic test_limit_extremes();
        write_limits(8'd255, 8'd255);
        send_item(make_item(bdht_pkg::MODE_FORCE, 7'd127, 1'b0, 1'b0));
        repeat (256) send_item(make_item(bdht_pkg::MODE_FAILURE, 7'd127));
        repeat (257) send_item(make_item(bdht_pkg::MODE_SUCCESS, 7'd127));
    endtask

    function automatic bdht_pkg::t_in_item random_item();
        bdht_pkg::t_in_item it;
        int unsigned pick;
        it.port = 1'($urandom_range(1));
        it.force_offline = 1'($urandom_range(1));
        it.address = ($urandom_range(99) < 60 && dev_count != 0) ?
                     health_table[$urandom_range(dev_count - 1)].addr : 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 12) it.mode = bdht_pkg::MODE_REGISTER;
        else if (pick < 27) it.mode = bdht_pkg::MODE_BUS;
        else if (pick < 42) it.mode = bdht_pkg::MODE_READ;
        else if (pick < 62) it.mode = bdht_pkg::MODE_FORCE;
        else if (pick < 66) it.mode = ($urandom_range(1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
        else if (pick < 83) it.mode = bdht_pkg::MODE_SUCCESS;
        else it.mode = bdht_pkg::MODE_FAILURE;
        return it;
    endfunction

    // Mostly runs of one outcome on a registered device, rest mixed items
    task automatic test_random_traffic(int unsigned n, int unsigned gap_pct,
                                       int unsigned stall_pct, logic [7:0] f, logic [7:0] r);
        bdht_pkg::t_in_item it;
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        write_limits(f, r);
        while (sent < n) begin
            if ($urandom_range(99) < 65 && dev_count != 0) begin
                it = random_item();
                it.mode = ($urandom_range(1) != 0) ? bdht_pkg::MODE_FAILURE
                                                   : bdht_pkg::MODE_SUCCESS;
                it.address = health_table[$urandom_range(dev_count - 1)].addr;
                burst = $urandom_range(1, (it.mode == bdht_pkg::MODE_FAILURE ?
                                           fail_lim : rec_lim) + 2);
                repeat (burst) send_item(it);
                sent += burst;
            end else begin
                it = random_item();
                send_item(it);
                if (it.mode <= bdht_pkg::MODE_FORCE) sent++;
            end
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : run_tests
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_gap_pct = 25;
        recv_stall_pct = 86;
        test_registration();
        test_hysteresis();
        test_forced_and_unused();
        test_limit_extremes();
        test_random_traffic(RANDOM_ITEMS / 3, 25, 86,
                            8'($urandom_range(2, 6)), 8'($urandom_range(2, 6)));
        test_random_traffic(RANDOM_ITEMS / 3, 86, 25, 8'd1, 8'd1);
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0,
                            8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
        wait_quiet();
        repeat (40) @(negedge clk);
        $display("summary: %0d items accepted, %0d reports scored, %0d mismatches",
                 items_sent, reports_seen, mismatches);
        $display("summary: %0d devices, limits 1 to 255, three idling mixes", dev_count);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
